>>> src/cbbr_pkg.sv
// Shared widths, side codes and the stage-two record for the bounce resolver.
package cbbr_pkg;

    // Field widths
    localparam int unsigned COORD_W  = 32;
    localparam int unsigned SIZE_W   = 31;
    localparam int unsigned RADIUS_W = 21;

    // Internal widths in doubled coordinates
    localparam int unsigned R2_W   = RADIUS_W + 1;   // doubled radius
    localparam int unsigned OFS_W  = COORD_W + 3;    // signed offset from box center
    localparam int unsigned DIST_W = COORD_W + 2;    // magnitude of that offset
    localparam int unsigned SQ_W   = 2 * R2_W;       // square of a corner distance
    localparam int unsigned SUM_W  = SQ_W + 1;       // sum of two squares
    localparam int unsigned MUL_W  = COORD_W + SIZE_W; // cross product for side choice

    // Side codes
    localparam logic [1:0] SIDE_NONE = 2'd0;
    localparam logic [1:0] SIDE_NEG  = 2'd1;
    localparam logic [1:0] SIDE_POS  = 2'd2;

    // Geometry of one item after the distance stage
    typedef struct packed {
        logic                      near;    // inside the far-rejection box
        logic                      band;    // inside an edge band
        logic [R2_W-1:0]           ea;      // x corner distance, clamped to r2
        logic [R2_W-1:0]           eb;      // y corner distance, clamped to r2
        logic [R2_W-1:0]           r2;      // doubled radius
        logic [COORD_W-1:0]        dx;      // doubled |offset x|, exact on a hit
        logic [COORD_W-1:0]        dy;      // doubled |offset y|, exact on a hit
        logic [SIZE_W-1:0]         w;
        logic [SIZE_W-1:0]         h;
        logic                      ox_neg;  // ball left of center
        logic                      oy_neg;  // ball below center
        logic signed [COORD_W-1:0] vx;
        logic signed [COORD_W-1:0] vy;
    } t_geom;

endpackage

>>> src/cbbr_in_if.sv
// Input channel: one ball state and one box per transfer.
interface cbbr_in_if
    import cbbr_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] ball_x;
    logic signed [COORD_W-1:0] ball_y;
    logic signed [COORD_W-1:0] ball_vx;
    logic signed [COORD_W-1:0] ball_vy;
    logic signed [COORD_W-1:0] rect_left;
    logic signed [COORD_W-1:0] rect_bottom;
    logic [SIZE_W-1:0]         rect_width;
    logic [SIZE_W-1:0]         rect_height;

    modport source (
        output valid, ball_x, ball_y, ball_vx, ball_vy,
               rect_left, rect_bottom, rect_width, rect_height,
        input  ready
    );
    modport sink (
        input  valid, ball_x, ball_y, ball_vx, ball_vy,
               rect_left, rect_bottom, rect_width, rect_height,
        output ready
    );
endinterface

>>> src/cbbr_out_if.sv
// Output channel: one resolved bounce per transfer.
interface cbbr_out_if
    import cbbr_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic                      hit;
    logic [1:0]                side_horiz;
    logic [1:0]                side_vert;
    logic signed [COORD_W-1:0] new_vx;
    logic signed [COORD_W-1:0] new_vy;

    modport source (
        output valid, hit, side_horiz, side_vert, new_vx, new_vy,
        input  ready
    );
    modport sink (
        input  valid, hit, side_horiz, side_vert, new_vx, new_vy,
        output ready
    );
endinterface

>>> src/cbbr_contact.sv
// Product and decision stages: squares and cross products, then hit, sides and velocity.
module cbbr_contact
    import cbbr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_geom             i_geom,
    input  logic              i_geom_valid,
    output logic              o_geom_ready,
    cbbr_out_if.source        o_out
);

    // Point a velocity component to the positive or the negative side
    function automatic logic signed [COORD_W-1:0] turn(
        input logic signed [COORD_W-1:0] v,
        input logic                      pos
    );
        logic signed [COORD_W-1:0] res;
        res = v;
        if (pos) begin
            if (v[COORD_W-1]) begin
                if (v == {1'b1, {(COORD_W-1){1'b0}}}) begin
                    res = {1'b0, {(COORD_W-1){1'b1}}};
                end else begin
                    res = -v;
                end
            end
        end else begin
            if (!v[COORD_W-1] && (v != '0)) begin
                res = -v;
            end
        end
        return res;
    endfunction

    logic                      r_s3_valid;
    logic                      r_s3_near;
    logic                      r_s3_band;
    logic [SQ_W-1:0]           r_s3_sq_a;
    logic [SQ_W-1:0]           r_s3_sq_b;
    logic [SQ_W-1:0]           r_s3_rr;
    logic [MUL_W-1:0]          r_s3_px;
    logic [MUL_W-1:0]          r_s3_py;
    logic                      r_s3_ox_neg;
    logic                      r_s3_oy_neg;
    logic signed [COORD_W-1:0] r_s3_vx;
    logic signed [COORD_W-1:0] r_s3_vy;

    logic                      r_s4_valid;
    logic                      r_hit;
    logic [1:0]                r_side_horiz;
    logic [1:0]                r_side_vert;
    logic signed [COORD_W-1:0] r_new_vx;
    logic signed [COORD_W-1:0] r_new_vy;

    logic en3;
    logic en4;

    logic                      n_hit;
    logic [1:0]                n_side_horiz;
    logic [1:0]                n_side_vert;
    logic signed [COORD_W-1:0] n_new_vx;
    logic signed [COORD_W-1:0] n_new_vy;
    logic [SUM_W-1:0]          corner_sum;
    logic                      corner;
    logic                      tx;
    logic                      ty;

    // Advance a stage when it is empty or its successor advances
    assign en4          = !r_s4_valid || o_out.ready;
    assign en3          = !r_s3_valid || en4;
    assign o_geom_ready = en3;

    // Stage three valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (en3) begin
            r_s3_valid <= i_geom_valid;
        end
    end

    // Stage three: corner squares and side cross products
    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_s3_near   <= i_geom.near;
            r_s3_band   <= i_geom.band;
            r_s3_sq_a   <= SQ_W'(i_geom.ea) * SQ_W'(i_geom.ea);
            r_s3_sq_b   <= SQ_W'(i_geom.eb) * SQ_W'(i_geom.eb);
            r_s3_rr     <= SQ_W'(i_geom.r2) * SQ_W'(i_geom.r2);
            r_s3_px     <= MUL_W'(i_geom.dx) * MUL_W'(i_geom.h);
            r_s3_py     <= MUL_W'(i_geom.dy) * MUL_W'(i_geom.w);
            r_s3_ox_neg <= i_geom.ox_neg;
            r_s3_oy_neg <= i_geom.oy_neg;
            r_s3_vx     <= i_geom.vx;
            r_s3_vy     <= i_geom.vy;
        end
    end

    // Stage four: decide hit, pick sides, turn velocity
    always_comb begin
        corner_sum   = SUM_W'(r_s3_sq_a) + SUM_W'(r_s3_sq_b);
        n_hit        = r_s3_near && (r_s3_band || (corner_sum <= SUM_W'(r_s3_rr)));
        corner       = corner_sum < SUM_W'(r_s3_rr);
        tx           = corner || (r_s3_px >= r_s3_py);
        ty           = corner || (r_s3_px <= r_s3_py);
        n_side_horiz = SIDE_NONE;
        n_side_vert  = SIDE_NONE;
        n_new_vx     = r_s3_vx;
        n_new_vy     = r_s3_vy;
        if (n_hit && tx) begin
            n_side_horiz = r_s3_ox_neg ? SIDE_NEG : SIDE_POS;
            n_new_vx     = turn(r_s3_vx, !r_s3_ox_neg);
        end
        if (n_hit && ty) begin
            n_side_vert = r_s3_oy_neg ? SIDE_NEG : SIDE_POS;
            n_new_vy    = turn(r_s3_vy, !r_s3_oy_neg);
        end
    end

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_valid <= 1'b0;
        end else if (en4) begin
            r_s4_valid <= r_s3_valid;
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (en4) begin
            r_hit        <= n_hit;
            r_side_horiz <= n_side_horiz;
            r_side_vert  <= n_side_vert;
            r_new_vx     <= n_new_vx;
            r_new_vy     <= n_new_vy;
        end
    end

    assign o_out.valid      = r_s4_valid;
    assign o_out.hit        = r_hit;
    assign o_out.side_horiz = r_side_horiz;
    assign o_out.side_vert  = r_side_vert;
    assign o_out.new_vx     = r_new_vx;
    assign o_out.new_vy     = r_new_vy;

endmodule

>>> src/circle_box_bounce_resolver_unit.sv
// Top level of the circle-box bounce resolver: radius register, offset and distance stages.
//
// Tests a ball (circle) against an axis-aligned box and, on contact, turns the
// velocity components of the struck side or sides away from the box center.
// One item is taken every clock while the output is not stalled; a result passes
// through the offset, distance, multiply and decide registers, the last of which is
// the output register. The multiply stage holds the corner squares and the two cross
// products used to pick the side. A stalled output holds every stage in place without
// loss. The radius register resets to 0.5 in Q format; the user must write it only
// while no item is in flight, as the block itself does not enforce this.
module circle_box_bounce_resolver_unit
    import cbbr_pkg::*;
#(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [RADIUS_W-1:0] i_cfg_wr_data,
    cbbr_in_if.sink             i_in,
    cbbr_out_if.source          o_out
);

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(1) << (FRAC_BITS - 1);

    logic [RADIUS_W-1:0]       r_ball_radius;

    logic                      r_s1_valid;
    logic signed [OFS_W-1:0]   r_s1_ox;
    logic signed [OFS_W-1:0]   r_s1_oy;
    logic [SIZE_W-1:0]         r_s1_w;
    logic [SIZE_W-1:0]         r_s1_h;
    logic signed [COORD_W-1:0] r_s1_vx;
    logic signed [COORD_W-1:0] r_s1_vy;

    logic                      r_s2_valid;
    t_geom                     r_s2_geom;

    logic                      en1;
    logic                      en2;
    logic                      s2_ready;

    logic signed [OFS_W-1:0]   n_ox;
    logic signed [OFS_W-1:0]   n_oy;
    t_geom                     n_geom;
    logic [DIST_W-1:0]         dx;
    logic [DIST_W-1:0]         dy;
    logic [DIST_W-1:0]         ea;
    logic [DIST_W-1:0]         eb;
    logic [R2_W-1:0]           r2;

    // Radius register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ball_radius <= RADIUS_RESET;
        end else if (i_cfg_wr_en) begin
            r_ball_radius <= i_cfg_wr_data;
        end
    end

    // Advance a stage when it is empty or its successor advances
    assign en2        = !r_s2_valid || s2_ready;
    assign en1        = !r_s1_valid || en2;
    assign i_in.ready = en1;

    // Stage one: doubled offsets from the box center
    always_comb begin
        n_ox = (OFS_W'(i_in.ball_x) <<< 1) - (OFS_W'(i_in.rect_left) <<< 1)
             - OFS_W'(i_in.rect_width);
        n_oy = (OFS_W'(i_in.ball_y) <<< 1) - (OFS_W'(i_in.rect_bottom) <<< 1)
             - OFS_W'(i_in.rect_height);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (en1) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1_ox <= n_ox;
            r_s1_oy <= n_oy;
            r_s1_w  <= i_in.rect_width;
            r_s1_h  <= i_in.rect_height;
            r_s1_vx <= i_in.ball_vx;
            r_s1_vy <= i_in.ball_vy;
        end
    end

    // Stage two: distances, far rejection, edge band, clamped corner distances
    always_comb begin
        r2 = {r_ball_radius, 1'b0};
        dx = DIST_W'(r_s1_ox[OFS_W-1] ? -r_s1_ox : r_s1_ox);
        dy = DIST_W'(r_s1_oy[OFS_W-1] ? -r_s1_oy : r_s1_oy);
        ea = (dx >= DIST_W'(r_s1_w)) ? dx - DIST_W'(r_s1_w) : DIST_W'(r_s1_w) - dx;
        eb = (dy >= DIST_W'(r_s1_h)) ? dy - DIST_W'(r_s1_h) : DIST_W'(r_s1_h) - dy;

        n_geom.near   = (dx <= DIST_W'(r_s1_w) + DIST_W'(r2))
                     && (dy <= DIST_W'(r_s1_h) + DIST_W'(r2));
        n_geom.band   = (dx <= DIST_W'(r_s1_w)) || (dy <= DIST_W'(r_s1_h));
        n_geom.ea     = (ea >= DIST_W'(r2)) ? r2 : ea[R2_W-1:0];
        n_geom.eb     = (eb >= DIST_W'(r2)) ? r2 : eb[R2_W-1:0];
        n_geom.r2     = r2;
        n_geom.dx     = dx[COORD_W-1:0];
        n_geom.dy     = dy[COORD_W-1:0];
        n_geom.w      = r_s1_w;
        n_geom.h      = r_s1_h;
        n_geom.ox_neg = r_s1_ox[OFS_W-1];
        n_geom.oy_neg = r_s1_oy[OFS_W-1];
        n_geom.vx     = r_s1_vx;
        n_geom.vy     = r_s1_vy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (en2) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_s2_geom <= n_geom;
        end
    end

    // Stages three and four
    cbbr_contact u_contact (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_geom       (r_s2_geom),
        .i_geom_valid (r_s2_valid),
        .o_geom_ready (s2_ready),
        .o_out        (o_out)
    );

endmodule

>>> verif/tb_circle_box_bounce_resolver_unit.sv
// Self-checking testbench for the circle-box bounce resolver, with its own bounce predictor.
module tb_circle_box_bounce_resolver_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import cbbr_pkg::*;

    localparam int ONE = 65536;    // 1.0 in Q16.16
    localparam int HALF = 32768;   // 0.5 in Q16.16
    localparam logic signed [COORD_W-1:0] V_MIN = 32'sh8000_0000;
    localparam logic signed [COORD_W-1:0] V_MAX = 32'sh7FFF_FFFF;
    localparam logic [SIZE_W-1:0] SIZE_MAX = 31'h7FFF_FFFF;
    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 21'd32768;
    localparam int unsigned RADIUS_TOP = 1048576;
    localparam int unsigned IDLE_PCT = 32;
    localparam int unsigned DRAIN_CYCLES = 10;
    localparam int unsigned ITEMS_PER_PHASE = 200;
    localparam int unsigned CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic signed [COORD_W-1:0] bx;
        logic signed [COORD_W-1:0] by;
        logic signed [COORD_W-1:0] vx;
        logic signed [COORD_W-1:0] vy;
        logic signed [COORD_W-1:0] left;
        logic signed [COORD_W-1:0] bottom;
        logic [SIZE_W-1:0]         w;
        logic [SIZE_W-1:0]         h;
    } t_ball_box;

    typedef struct packed {
        logic                      hit;
        logic [1:0]                side_h;
        logic [1:0]                side_v;
        logic signed [COORD_W-1:0] vx;
        logic signed [COORD_W-1:0] vy;
    } t_bounce;

    typedef struct {
        t_ball_box req;
        bit        typed;
        t_bounce   res;
    } t_stim_row;

    logic                i_clk;
    logic                i_rst_n;
    logic                cfg_wr_en;
    logic [RADIUS_W-1:0] cfg_wr_data;
    logic [RADIUS_W-1:0] radius_now;
    bit                  calm;
    int                  errors;
    int unsigned         cycle_count;
    t_bounce             expected_bounces[$];
    t_stim_row           directed_rows[$];

    cbbr_in_if  in_if ();
    cbbr_out_if out_if ();

    circle_box_bounce_resolver_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in          (in_if),
        .o_out         (out_if)
    );

    // Point a velocity component to the positive or negative side
    function automatic logic signed [COORD_W-1:0] turn_away(
        input logic signed [COORD_W-1:0] v, input bit to_pos);
        if (to_pos) begin
            if (v >= 0) return v;
            if (v == V_MIN) return V_MAX;
            return -v;
        end
        return (v <= 0) ? v : -v;
    endfunction

    // Predict the bounce in doubled coordinates so box halves stay exact
    function automatic t_bounce resolve_bounce(input t_ball_box b,
                                               input logic [RADIUS_W-1:0] rad);
        longint          ox, oy;
        longint unsigned w, h, r2, dx, dy, ea, eb, px, py;
        logic            touch, turn_x, turn_y;
        t_bounce         r;
        w  = b.w;
        h  = b.h;
        r2 = 2 * longint'(rad);
        ox = 2 * longint'(b.bx) - (2 * longint'(b.left) + longint'(w));
        oy = 2 * longint'(b.by) - (2 * longint'(b.bottom) + longint'(h));
        dx = (ox < 0) ? -ox : ox;
        dy = (oy < 0) ? -oy : oy;
        if (dx > w + r2 || dy > h + r2) begin
            touch = 1'b0;
        end else if (dx <= w || dy <= h) begin
            touch = 1'b1;
        end else begin
            touch = ((dx - w) * (dx - w) + (dy - h) * (dy - h)) <= r2 * r2;
        end
        r.hit    = touch;
        r.side_h = SIDE_NONE;
        r.side_v = SIDE_NONE;
        r.vx     = b.vx;
        r.vy     = b.vy;
        if (touch) begin
            ea = (dx >= w) ? dx - w : w - dx;
            eb = (dy >= h) ? dy - h : h - dy;
            // strict corner hit turns both, otherwise cross-multiplied side choice
            if (ea * ea + eb * eb < r2 * r2) begin
                turn_x = 1'b1;
                turn_y = 1'b1;
            end else begin
                px = dx * h;
                py = dy * w;
                turn_x = px >= py;
                turn_y = px <= py;
            end
            if (turn_x) begin
                r.side_h = (ox < 0) ? SIDE_NEG : SIDE_POS;
                r.vx     = turn_away(b.vx, ox >= 0);
            end
            if (turn_y) begin
                r.side_v = (oy < 0) ? SIDE_NEG : SIDE_POS;
                r.vy     = turn_away(b.vy, oy >= 0);
            end
        end
        return r;
    endfunction

    // Append one directed row; the result is typed in only where it is obvious
    function automatic void add_row(
        input logic signed [COORD_W-1:0] bx, by, vx, vy, left, bottom,
        input logic [SIZE_W-1:0] w, h,
        input bit typed = 1'b0, input logic hit = 1'b0,
        input logic [1:0] sh = SIDE_NONE, input logic [1:0] sv = SIDE_NONE,
        input logic signed [COORD_W-1:0] nvx = 0, input logic signed [COORD_W-1:0] nvy = 0);
        t_stim_row row;
        row.req   = '{bx, by, vx, vy, left, bottom, w, h};
        row.typed = typed;
        row.res   = '{hit, sh, sv, nvx, nvy};
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    function automatic logic signed [COORD_W-1:0] pick_velocity();
        case ($urandom_range(19, 0))
            0: return V_MIN;
            1: return V_MAX;
            2: return 0;
            3: return -1;
            default: return $urandom();
        endcase
    endfunction

    // Draw one ball and box, mostly close enough to the box to touch it
    function automatic t_ball_box pick_ball_box(input int unsigned rad);
        t_ball_box   b;
        int unsigned roll;
        longint      margin, xoff, yoff, d;
        roll = $urandom_range(99, 0);
        b.vx = pick_velocity();
        b.vy = pick_velocity();
        if (roll < 12) begin
            b.bx     = $urandom();
            b.by     = $urandom();
            b.left   = $urandom();
            b.bottom = $urandom();
            b.w      = $urandom_range(SIZE_MAX, 1);
            b.h      = $urandom_range(SIZE_MAX, 1);
            return b;
        end
        b.w = ($urandom_range(9, 0) == 0) ? $urandom_range(1 << 30, 1)
                                          : $urandom_range(8 * ONE, 1);
        b.h = ($urandom_range(9, 0) == 0) ? $urandom_range(1 << 30, 1)
                                          : $urandom_range(8 * ONE, 1);
        if (roll < 35) b.h = b.w;
        b.left   = $urandom_range(1 << 30, 0) - 32'd536870912;
        b.bottom = $urandom_range(1 << 30, 0) - 32'd536870912;
        margin   = longint'(rad) + ONE;
        case ($urandom_range(3, 0))
            0: begin
                xoff = longint'($urandom_range(b.w + 2 * margin, 0)) - margin;
                yoff = longint'($urandom_range(b.h + 2 * margin, 0)) - margin;
            end
            1: begin
                // near a corner
                xoff = $urandom_range(1, 0) ? longint'(b.w) + $urandom_range(rad, 0)
                                            : -longint'($urandom_range(rad, 0));
                yoff = $urandom_range(1, 0) ? longint'(b.h) + $urandom_range(rad, 0)
                                            : -longint'($urandom_range(rad, 0));
            end
            2: begin
                // on a center line, or on both
                b.w[0] = 1'b0;
                b.h[0] = 1'b0;
                if (b.w == 0) b.w = 2;
                if (b.h == 0) b.h = 2;
                xoff = longint'($urandom_range(b.w + 2 * margin, 0)) - margin;
                yoff = longint'($urandom_range(b.h + 2 * margin, 0)) - margin;
                case ($urandom_range(2, 0))
                    0: xoff = b.w / 2;
                    1: yoff = b.h / 2;
                    default: begin
                        xoff = b.w / 2;
                        yoff = b.h / 2;
                    end
                endcase
            end
            default: begin
                // on a diagonal of a square box: side choice ties
                b.w[0] = 1'b0;
                if (b.w == 0) b.w = 2;
                b.h  = b.w;
                d    = $urandom_range(b.w / 2 + margin, 0);
                xoff = $urandom_range(1, 0) ? b.w / 2 + d : b.w / 2 - d;
                yoff = $urandom_range(1, 0) ? b.h / 2 + d : b.h / 2 - d;
            end
        endcase
        b.bx = longint'(b.left) + xoff;
        b.by = longint'(b.bottom) + yoff;
        return b;
    endfunction

    // Offer one item, then record its expected bounce on the transfer
    task automatic send_ball(input t_ball_box b, input bit typed = 1'b0,
                             input t_bounce res = '0);
        while (!calm && $urandom_range(99, 0) < IDLE_PCT) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.ball_x      <= b.bx;
        in_if.ball_y      <= b.by;
        in_if.ball_vx     <= b.vx;
        in_if.ball_vy     <= b.vy;
        in_if.rect_left   <= b.left;
        in_if.rect_bottom <= b.bottom;
        in_if.rect_width  <= b.w;
        in_if.rect_height <= b.h;
        do @(posedge i_clk); while (!in_if.ready);
        expected_bounces.insert(expected_bounces.size(),
                                typed ? res : resolve_bounce(b, radius_now));
        @(negedge i_clk);
    endtask

    // Drain the pipeline, then write the radius while nothing is in flight
    task automatic set_radius(input logic [RADIUS_W-1:0] value);
        in_if.valid <= 1'b0;
        while (expected_bounces.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        radius_now  = value;
        @(negedge i_clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Output stall pattern
    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_if.ready <= calm || ($urandom_range(99, 0) >= IDLE_PCT);
        end
    end

    // Run limit
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: run limit reached", $time);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Compare each result transfer with the oldest expected bounce
    always @(posedge i_clk) begin
        t_bounce want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (expected_bounces.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual hit %b vx %h vy %h",
                         $time, out_if.hit, out_if.new_vx, out_if.new_vy);
                errors++;
            end else begin
                want = expected_bounces.pop_front();
                if (out_if.hit !== want.hit) begin
                    $display("%0t: hit expected %b actual %b", $time, want.hit, out_if.hit);
                    errors++;
                end
                if (out_if.side_horiz !== want.side_h) begin
                    $display("%0t: side_horiz expected %0d actual %0d", $time,
                             want.side_h, out_if.side_horiz);
                    errors++;
                end
                if (out_if.side_vert !== want.side_v) begin
                    $display("%0t: side_vert expected %0d actual %0d", $time,
                             want.side_v, out_if.side_vert);
                    errors++;
                end
                if (out_if.new_vx !== want.vx) begin
                    $display("%0t: new_vx expected %h actual %h", $time, want.vx, out_if.new_vx);
                    errors++;
                end
                if (out_if.new_vy !== want.vy) begin
                    $display("%0t: new_vy expected %h actual %h", $time, want.vy, out_if.new_vy);
                    errors++;
                end
            end
        end
    end

    // Stimulus
    initial begin
        int unsigned radius_plan[7];
        errors            = 0;
        calm              = 1'b0;
        radius_now        = RADIUS_RESET;
        i_rst_n           = 1'b0;
        cfg_wr_en         = 1'b0;
        cfg_wr_data       = '0;
        in_if.valid       = 1'b0;
        in_if.ball_x      = '0;
        in_if.ball_y      = '0;
        in_if.ball_vx     = '0;
        in_if.ball_vy     = '0;
        in_if.rect_left   = '0;
        in_if.rect_bottom = '0;
        in_if.rect_width  = '0;
        in_if.rect_height = '0;

        // Directed rows at the reset radius: ball x, y, vx, vy, box left, bottom, w, h
        // far miss: velocity passes through
        add_row(100 * ONE, 100 * ONE, ONE, -ONE, 0, 0, ONE, ONE,
                1'b1, 1'b0, SIDE_NONE, SIDE_NONE, ONE, -ONE);
        // ball at the box center: tie, both turn positive
        add_row(ONE, ONE, -ONE, -ONE, 0, 0, 2 * ONE, 2 * ONE,
                1'b1, 1'b1, SIDE_POS, SIDE_POS, ONE, ONE);
        // most negative velocity turned positive saturates
        add_row(ONE, ONE, V_MIN, V_MIN, 0, 0, 2 * ONE, 2 * ONE,
                1'b1, 1'b1, SIDE_POS, SIDE_POS, V_MAX, V_MAX);
        // left of center: most negative stays, y passes through
        add_row(HALF, ONE, V_MIN, 12345, 0, 0, 2 * ONE, 2 * ONE,
                1'b1, 1'b1, SIDE_NEG, SIDE_NONE, V_MIN, 12345);
        // one step beyond the left touch point: miss
        add_row(-HALF - 1, ONE, ONE, ONE, 0, 0, 2 * ONE, 2 * ONE,
                1'b1, 1'b0, SIDE_NONE, SIDE_NONE, ONE, ONE);
        // far miss at the coordinate extremes
        add_row(V_MIN, V_MIN, V_MAX, V_MIN, V_MAX, V_MAX, 1, 1,
                1'b1, 1'b0, SIDE_NONE, SIDE_NONE, V_MAX, V_MIN);
        add_row(-HALF, ONE, ONE, -ONE, 0, 0, 2 * ONE, 2 * ONE);          // left edge touch
        add_row(ONE, 2 * ONE + HALF / 2, -ONE, -ONE, 0, 0, 2 * ONE, 2 * ONE); // top band
        add_row(ONE, -HALF / 2, ONE, ONE, 0, 0, 2 * ONE, 2 * ONE);       // bottom band
        add_row(2 * ONE + HALF / 2, ONE, -ONE, 7, 0, 0, 2 * ONE, 2 * ONE); // right, center line
        add_row(2 * ONE + HALF / 2, -HALF / 2, -ONE, ONE, 0, 0, 2 * ONE, 2 * ONE); // corner hit
        add_row(2 * ONE + 24000, -24000, -ONE, ONE, 0, 0, 2 * ONE, 2 * ONE); // corner miss
        add_row(-HALF / 2, 2 * ONE + HALF / 2, ONE, -ONE, 0, 0, 2 * ONE, 2 * ONE); // top left
        add_row(ONE + 1000, ONE + 1000, -5, -9, 0, 0, 2 * ONE, 2 * ONE); // diagonal tie
        add_row(ONE - 1000, ONE + 1000, 5, -9, 0, 0, 2 * ONE, 2 * ONE);  // diagonal tie
        add_row(V_MAX, V_MIN, V_MAX, V_MIN, V_MIN, V_MAX, SIZE_MAX, 1);
        add_row(0, 0, V_MAX, V_MIN, V_MIN, V_MIN, SIZE_MAX, SIZE_MAX);
        add_row(0, 0, V_MAX, V_MIN, 0, 0, 1, 1);                         // tiny box
        add_row(0, HALF, 0, 0, -ONE, 0, 2 * ONE, 1);                     // thin box, zero speed
        add_row(-1, -1, -1, -1, 0, 0, SIZE_MAX, SIZE_MAX);
        add_row(HALF, -1, V_MAX, V_MAX, 0, 0, ONE, SIZE_MAX);

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[k]) begin
            send_ball(directed_rows[k].req, directed_rows[k].typed, directed_rows[k].res);
        end

        // Random phases, each at its own radius; one phase runs without any stalls
        radius_plan = '{0, RADIUS_TOP, 1, ONE, $urandom_range(RADIUS_TOP, 0),
                        $urandom_range(RADIUS_TOP, 0), HALF};
        foreach (radius_plan[p]) begin
            set_radius(radius_plan[p]);
            calm = (p == 3);
            repeat (ITEMS_PER_PHASE) send_ball(pick_ball_box(radius_now));
        end
        calm = 1'b0;

        // Drain and report
        in_if.valid <= 1'b0;
        while (expected_bounces.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
